[rtl/core/timed_thermostat_controller_unit_assert.svh]
// Assertion macros for the timed thermostat controller.
// Expects signals named clock and reset in the including module.
`ifndef TIMED_THERMOSTAT_CONTROLLER_UNIT_ASSERT_SVH
`define TIMED_THERMOSTAT_CONTROLLER_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define TTC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication.
`define TTC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[rtl/core/ttc_pkg.sv]
// Shared types and constants for the timed thermostat controller.
// No dependencies.
package ttc_pkg;

   // request kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_ADC   = 2'd2;
   localparam logic [1:0] KIND_START = 2'd3;

   // controller modes
   localparam logic [1:0] MODE_WAIT  = 2'd0;
   localparam logic [1:0] MODE_ARMED = 2'd1;
   localparam logic [1:0] MODE_HEAT  = 2'd2;
   localparam logic [1:0] MODE_REG   = 2'd3;

   // register indexes
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN  = 4'd1;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_DATA_W-1:0] TICKS_RESET = 10'd1000;
   localparam logic [CSR_DATA_W-1:0] GAIN_RESET  = 10'd488;

   // characters
   localparam logic [7:0] CHAR_CR   = 8'd13;
   localparam logic [7:0] CHAR_ZERO = 8'd48;
   localparam logic [7:0] CHAR_NINE = 8'd57;

   // parameter defaults
   localparam int RX_BUFFER_LEN_DEF    = 20;
   localparam int TIME_FIELD_START_DEF = 8;

   // temperature arithmetic
   localparam int TEMP_W      = 20;            // thousandths of a degree
   localparam int SP_MILLI_W  = 17;            // setpoint in thousandths, max 99900
   localparam int SEC_W       = 16;
   localparam int DIV_K       = 30;            // x/1000 == (x*DIV_MUL)>>DIV_K, x < 2^20
   localparam int DIV_MUL_W   = 21;
   localparam logic [DIV_MUL_W-1:0] DIV_MUL = 21'd1073742;
   localparam int QUOT_W      = 11;            // max 1046
   localparam int DIV10_K     = 11;            // x/10 == (x*205)>>11, x < 1029
   localparam logic [7:0] DIV10_MUL = 8'd205;

   typedef struct packed {
      logic [1:0] kind;
      logic [9:0] payload;
   } req_type;

   typedef struct packed {
      logic        heater_on;
      logic [1:0]  mode;
      logic        sample_request;
      logic        show_waiting;
      logic        display_changed;
      logic [9:0]  shown_degrees;
      logic [6:0]  shown_hundredths;
      logic [15:0] shown_seconds;
   } rsp_type;

   // decoded request as it moves down the front pipeline
   typedef struct packed {
      logic [1:0]        kind;
      logic              is_cr;
      logic [3:0]        digit;
      logic [TEMP_W-1:0] product;
      logic [QUOT_W-1:0] quot;
      logic [6:0]        hund;
   } evt_type;

endpackage

[rtl/core/timed_thermostat_controller_unit.sv]
// Timed thermostat controller, top level.
// Depends on ttc_pkg and timed_thermostat_controller_unit_assert.svh.

// Bang-bang heater controller with a countdown, driven by one event per
// request (serial byte, 1 ms tick, ADC sample, start press) and answering each
// request with exactly one response. Requests are accepted one per clock while
// the pipeline is not stalled; each passes stage registers s1, s2 and s3, then
// the response register. The front three stages depend on the request and the
// gain CSR alone (ADC scaling multiply, divide by 1000 through a reciprocal
// multiply, hundredths by a small constant multiply); the last stage updates the
// controller state and loads the response register, so one request per cycle
// is sustained with no hazards while the receiver takes responses. Each stage
// stalls only when the stage after it is full and not moving, so empty stages
// keep taking requests while a response waits. CSR writes are always ready and
// take effect at once; write them only while the block is idle.
module timed_thermostat_controller_unit #(
   parameter int RX_BUFFER_LEN    = ttc_pkg::RX_BUFFER_LEN_DEF,
   parameter int TIME_FIELD_START = ttc_pkg::TIME_FIELD_START_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ttc_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ttc_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ttc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ttc_pkg::CSR_DATA_W-1:0]   csr_data
);

   // receive position must hold the buffer length and the time field start
   localparam int POS_MAX = (RX_BUFFER_LEN > TIME_FIELD_START) ?
                            RX_BUFFER_LEN : TIME_FIELD_START;
   localparam int POS_W = $clog2(POS_MAX + 1);
   localparam logic [POS_W-1:0] RX_LEN_P   = POS_W'(RX_BUFFER_LEN);
   localparam logic [POS_W-1:0] TIME_POS_P = POS_W'(TIME_FIELD_START);
   localparam logic [POS_W-1:0] POS_TENS   = POS_W'(2);
   localparam logic [POS_W-1:0] POS_UNITS  = POS_W'(3);
   localparam logic [POS_W-1:0] POS_TENTH  = POS_W'(5);

   localparam int TW = ttc_pkg::TEMP_W;
   localparam int SW = ttc_pkg::SEC_W;
   localparam int MW = ttc_pkg::SP_MILLI_W;

   // ------------------------------------------------------------------
   // CSRs
   // ------------------------------------------------------------------
   logic [ttc_pkg::CSR_DATA_W-1:0] ticks_ff;
   logic [ttc_pkg::CSR_DATA_W-1:0] gain_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= ttc_pkg::TICKS_RESET;
         gain_ff  <= ttc_pkg::GAIN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            ttc_pkg::CSR_TICKS: ticks_ff <= csr_data;
            ttc_pkg::CSR_GAIN:  gain_ff  <= csr_data;
            default: ;   // unknown index, dropped
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control
   // ------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic rdy1, rdy2, rdy3, out_rdy, fire;

   assign out_rdy   = !rsp_valid_ff || rsp_ready;
   assign fire      = v3_ff && out_rdy;
   assign rdy3      = !v3_ff || out_rdy;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1)    v1_ff        <= req_valid;
         if (rdy2)    v2_ff        <= v1_ff;
         if (rdy3)    v3_ff        <= v2_ff;
         if (out_rdy) rsp_valid_ff <= v3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: decode byte, scale ADC sample
   // ------------------------------------------------------------------
   ttc_pkg::evt_type s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;
   logic [7:0]    rx_byte;
   logic [TW-1:0] scaled;

   assign rx_byte = req_data.payload[7:0];
   assign scaled  = TW'(req_data.payload) * TW'(gain_ff);

   always_comb begin
      s1_in         = '0;
      s1_in.kind    = req_data.kind;
      s1_in.is_cr   = (rx_byte == ttc_pkg::CHAR_CR);
      // non-digit counts as zero
      if (rx_byte >= ttc_pkg::CHAR_ZERO && rx_byte <= ttc_pkg::CHAR_NINE) begin
         s1_in.digit = 4'(rx_byte - ttc_pkg::CHAR_ZERO);
      end
      s1_in.product = scaled;
   end

   // ------------------------------------------------------------------
   // Stage 2: whole degrees = product / 1000 via reciprocal
   // ------------------------------------------------------------------
   localparam int RECIP_W = TW + ttc_pkg::DIV_MUL_W;
   logic [RECIP_W-1:0] recip;

   assign recip = RECIP_W'(s1_ff.product) * RECIP_W'(ttc_pkg::DIV_MUL);

   always_comb begin
      s2_in      = s1_ff;
      s2_in.quot = recip[ttc_pkg::DIV_K +: ttc_pkg::QUOT_W];
   end

   // ------------------------------------------------------------------
   // Stage 3: hundredths = (product mod 1000) / 10
   // ------------------------------------------------------------------
   logic [TW-1:0] rem_full;
   logic [17:0]   hund_full;

   assign rem_full  = s2_ff.product - TW'(s2_ff.quot) * TW'(1000);
   assign hund_full = 18'(rem_full[9:0]) * 18'(ttc_pkg::DIV10_MUL);

   always_comb begin
      s3_in      = s2_ff;
      s3_in.hund = hund_full[ttc_pkg::DIV10_K +: 7];
   end

   always_ff @(posedge clock) begin
      if (req_valid && rdy1) s1_ff <= s1_in;
      if (v1_ff && rdy2)     s2_ff <= s2_in;
      if (v2_ff && rdy3)     s3_ff <= s3_in;
   end

   // ------------------------------------------------------------------
   // Stage 4: controller state and response register
   // ------------------------------------------------------------------
   logic [1:0]       mode_ff, mode_in, mode_mid;
   logic             heater_ff, heater_in;
   logic             cnt_en_ff, cnt_en_in;
   logic             wpend_ff, wpend_in;
   logic [9:0]       tick_ff, tick_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]       p_tens_ff, p_tens_in, p_units_ff, p_units_in, p_tenth_ff, p_tenth_in;
   logic [SW-1:0]    p_sec_ff, p_sec_in;
   logic [3:0]       s_tens_ff, s_tens_in, s_units_ff, s_units_in, s_tenth_ff, s_tenth_in;
   logic [MW-1:0]    s_milli_ff, s_milli_in;
   logic [SW-1:0]    sec_left_ff, sec_left_in;
   logic [TW-1:0]    temp_ff, temp_in;
   logic [9:0]       t_deg_ff, t_deg_in;
   logic [6:0]       t_hund_ff, t_hund_in;
   logic [9:0]       sh_deg_ff, sh_deg_in;
   logic [6:0]       sh_hund_ff, sh_hund_in;
   logic [SW-1:0]    sh_sec_ff, sh_sec_in;
   ttc_pkg::rsp_type rsp_ff, rsp_in;

   logic             reached, sample_req, show_wait;
   logic [19:0]      sec_acc;
   logic [MW-1:0]    p_milli;

   // setpoint of the pending command, thousandths of a degree
   assign p_milli = MW'(p_tens_ff) * MW'(10000) + MW'(p_units_ff) * MW'(1000) +
                    MW'(p_tenth_ff) * MW'(100);
   assign sec_acc = 20'(p_sec_ff) * 20'd10 + 20'(s3_ff.digit);

   always_comb begin
      mode_mid    = mode_ff;
      heater_in   = heater_ff;
      cnt_en_in   = cnt_en_ff;
      wpend_in    = wpend_ff;
      tick_in     = tick_ff;
      pos_in      = pos_ff;
      p_tens_in   = p_tens_ff;
      p_units_in  = p_units_ff;
      p_tenth_in  = p_tenth_ff;
      p_sec_in    = p_sec_ff;
      s_tens_in   = s_tens_ff;
      s_units_in  = s_units_ff;
      s_tenth_in  = s_tenth_ff;
      s_milli_in  = s_milli_ff;
      sec_left_in = sec_left_ff;
      temp_in     = temp_ff;
      t_deg_in    = t_deg_ff;
      t_hund_in   = t_hund_ff;
      sample_req  = 1'b0;
      show_wait   = 1'b0;

      // event phase
      case (s3_ff.kind)
         ttc_pkg::KIND_BYTE: begin
            if (s3_ff.is_cr) begin
               // load and arm; heater and countdown enable untouched
               s_tens_in   = p_tens_ff;
               s_units_in  = p_units_ff;
               s_tenth_in  = p_tenth_ff;
               s_milli_in  = p_milli;
               sec_left_in = p_sec_ff;
               mode_mid    = ttc_pkg::MODE_ARMED;
               pos_in      = '0;
               p_tens_in   = '0;
               p_units_in  = '0;
               p_tenth_in  = '0;
               p_sec_in    = '0;
            end else if (pos_ff < RX_LEN_P) begin
               if (pos_ff == POS_TENS)  p_tens_in  = s3_ff.digit;
               if (pos_ff == POS_UNITS) p_units_in = s3_ff.digit;
               if (pos_ff == POS_TENTH) p_tenth_in = s3_ff.digit;
               if (pos_ff >= TIME_POS_P) begin
                  p_sec_in = (sec_acc > 20'hFFFF) ? '1 : sec_acc[SW-1:0];
               end
               pos_in = pos_ff + POS_W'(1);
            end
         end
         ttc_pkg::KIND_TICK: begin
            if (tick_ff >= ticks_ff) begin
               tick_in    = '0;
               sample_req = 1'b1;
               if (cnt_en_ff && sec_left_ff != '0) sec_left_in = sec_left_ff - SW'(1);
            end else begin
               tick_in = tick_ff + 10'd1;
            end
         end
         ttc_pkg::KIND_ADC: begin
            temp_in   = s3_ff.product;
            t_deg_in  = s3_ff.quot[9:0];
            t_hund_in = s3_ff.hund;
         end
         ttc_pkg::KIND_START: begin
            if (mode_ff == ttc_pkg::MODE_ARMED) begin
               heater_in = 1'b1;
               mode_mid  = ttc_pkg::MODE_HEAT;
            end
         end
         default: ;
      endcase

      reached    = (temp_in >= TW'(s_milli_in));
      mode_in    = mode_mid;
      sh_deg_in  = sh_deg_ff;
      sh_hund_in = sh_hund_ff;
      sh_sec_in  = sh_sec_ff;

      // mode phase
      case (mode_mid)
         ttc_pkg::MODE_WAIT: begin
            // shown values hold
            if (wpend_ff) begin
               show_wait = 1'b1;
               wpend_in  = 1'b0;
            end
         end
         ttc_pkg::MODE_ARMED: begin
            sh_deg_in  = 10'(s_tens_in) * 10'd10 + 10'(s_units_in);
            sh_hund_in = 7'(s_tenth_in) * 7'd10;
            sh_sec_in  = sec_left_in;
         end
         ttc_pkg::MODE_HEAT: begin
            sh_deg_in  = t_deg_in;
            sh_hund_in = t_hund_in;
            sh_sec_in  = sec_left_in;
            if (reached) mode_in = ttc_pkg::MODE_REG;
         end
         default: begin
            // regulating with countdown
            cnt_en_in  = 1'b1;
            sh_deg_in  = t_deg_in;
            sh_hund_in = t_hund_in;
            sh_sec_in  = sec_left_in;
            heater_in  = !reached;
            if (sec_left_in == '0) begin
               mode_in    = ttc_pkg::MODE_WAIT;
               heater_in  = 1'b0;
               cnt_en_in  = 1'b0;
               wpend_in   = 1'b1;
               s_tens_in  = '0;
               s_units_in = '0;
               s_tenth_in = '0;
               s_milli_in = '0;
               pos_in     = '0;
               p_tens_in  = '0;
               p_units_in = '0;
               p_tenth_in = '0;
               p_sec_in   = '0;
            end
         end
      endcase

      rsp_in.heater_on        = heater_in;
      rsp_in.mode             = mode_in;
      rsp_in.sample_request   = sample_req;
      rsp_in.show_waiting     = show_wait;
      rsp_in.display_changed  = (sh_deg_in != sh_deg_ff) || (sh_hund_in != sh_hund_ff) ||
                                (sh_sec_in != sh_sec_ff);
      rsp_in.shown_degrees    = sh_deg_in;
      rsp_in.shown_hundredths = sh_hund_in;
      rsp_in.shown_seconds    = sh_sec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ttc_pkg::MODE_WAIT;
         heater_ff   <= 1'b0;
         cnt_en_ff   <= 1'b0;
         wpend_ff    <= 1'b1;
         tick_ff     <= '0;
         pos_ff      <= '0;
         p_tens_ff   <= '0;
         p_units_ff  <= '0;
         p_tenth_ff  <= '0;
         p_sec_ff    <= '0;
         s_tens_ff   <= '0;
         s_units_ff  <= '0;
         s_tenth_ff  <= '0;
         s_milli_ff  <= '0;
         sec_left_ff <= '0;
         temp_ff     <= '0;
         t_deg_ff    <= '0;
         t_hund_ff   <= '0;
         sh_deg_ff   <= '0;
         sh_hund_ff  <= '0;
         sh_sec_ff   <= '0;
      end else if (fire) begin
         mode_ff     <= mode_in;
         heater_ff   <= heater_in;
         cnt_en_ff   <= cnt_en_in;
         wpend_ff    <= wpend_in;
         tick_ff     <= tick_in;
         pos_ff      <= pos_in;
         p_tens_ff   <= p_tens_in;
         p_units_ff  <= p_units_in;
         p_tenth_ff  <= p_tenth_in;
         p_sec_ff    <= p_sec_in;
         s_tens_ff   <= s_tens_in;
         s_units_ff  <= s_units_in;
         s_tenth_ff  <= s_tenth_in;
         s_milli_ff  <= s_milli_in;
         sec_left_ff <= sec_left_in;
         temp_ff     <= temp_in;
         t_deg_ff    <= t_deg_in;
         t_hund_ff   <= t_hund_in;
         sh_deg_ff   <= sh_deg_in;
         sh_hund_ff  <= sh_hund_in;
         sh_sec_ff   <= sh_sec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
`include "timed_thermostat_controller_unit_assert.svh"

   `TTC_ASSERT_IMPLY(a_wait_heater_off,
      rsp_valid_ff && rsp_ff.mode == ttc_pkg::MODE_WAIT, !rsp_ff.heater_on,
      "heater on while waiting")
   `TTC_ASSERT_IMPLY(a_show_wait_mode,
      rsp_valid_ff && rsp_ff.show_waiting, rsp_ff.mode == ttc_pkg::MODE_WAIT,
      "waiting message outside waiting mode")
   `TTC_ASSERT_IMPLY(a_sample_tick_clear,
      rsp_valid_ff && rsp_ff.sample_request, tick_ff == '0,
      "sample request without tick counter restart")
   `TTC_ASSERT_IMPLY(a_wait_countdown_off,
      rsp_valid_ff && rsp_ff.mode == ttc_pkg::MODE_WAIT, !cnt_en_ff,
      "countdown enabled while waiting")
   `TTC_ASSERT_ALWAYS(a_pos_bound, pos_ff <= RX_LEN_P, "receive position past buffer length")

endmodule

[bench/tb_timed_thermostat_controller_unit.sv]
// Self-checking bench for timed_thermostat_controller_unit: directed and random events.
// Depends on ttc_pkg and the controller RTL only.
module tb_timed_thermostat_controller_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // digit positions inside a command line
   localparam int POS_TENS   = 2;
   localparam int POS_UNITS  = 3;
   localparam int POS_POINT  = 4;
   localparam int POS_TENTHS = 5;

   // a register index the block does not decode
   localparam logic [ttc_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 4'd15;

   localparam int LATENCY_SLACK   = 8;       // pipeline is four deep
   localparam int HOLD_OFF_CYCLES = 100;     // long receiver stall
   localparam int CYCLE_LIMIT     = 400000;

   // ---------------------------------------------------------------------
   // DUT hookup; every input is known from time zero
   // ---------------------------------------------------------------------
   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   ttc_pkg::req_type                req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   ttc_pkg::rsp_type                rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [ttc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ttc_pkg::CSR_DATA_W-1:0]  csr_data  = '0;

   timed_thermostat_controller_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Controller shadow: configuration, state and the display registers
   // ---------------------------------------------------------------------
   logic [9:0]  cfg_period       = ttc_pkg::TICKS_RESET;
   logic [9:0]  cfg_gain         = ttc_pkg::GAIN_RESET;

   logic [1:0]  ctl_mode         = ttc_pkg::MODE_WAIT;
   logic        ctl_heater       = 1'b0;
   logic        ctl_countdown_on = 1'b0;
   logic        ctl_wait_msg_due = 1'b1;
   logic [9:0]  ctl_tick_count   = '0;
   logic [4:0]  ctl_rx_pos       = '0;
   logic [15:0] ctl_sp_accum     = '0;
   logic [15:0] ctl_sec_accum    = '0;
   logic [15:0] ctl_setpoint     = '0;    // tenths of a degree
   logic [15:0] ctl_secs_left    = '0;
   logic [19:0] ctl_temp_milli   = '0;
   logic [9:0]  disp_deg         = '0;
   logic [6:0]  disp_hund        = '0;
   logic [15:0] disp_sec         = '0;

   ttc_pkg::rsp_type outputs_due[$];      // one entry per accepted request
   int unsigned items_sent   = 0;
   int unsigned mismatches   = 0;
   int unsigned cycle_count  = 0;
   bit          sender_gaps  = 1'b1;
   bit          hold_off_request = 1'b0;
   int unsigned rsp_stall_left = 0;
   int unsigned rsp_burst_left = 0;

   // Applies one event to the shadow and returns the display/flags it yields.
   function automatic ttc_pkg::rsp_type advance_controller(input ttc_pkg::req_type item);
      ttc_pkg::rsp_type o;
      logic [7:0]  b;
      int unsigned d, acc, deg, hund, sec;
      logic        period_done, wait_msg, reached;
      period_done = 1'b0;
      wait_msg    = 1'b0;
      deg  = disp_deg;
      hund = disp_hund;
      sec  = disp_sec;
      b    = item.payload[7:0];

      case (item.kind)
         ttc_pkg::KIND_BYTE: begin
            if (b == ttc_pkg::CHAR_CR) begin
               // CR latches the command and arms, whatever the mode
               ctl_setpoint  = ctl_sp_accum;
               ctl_secs_left = ctl_sec_accum;
               ctl_mode      = ttc_pkg::MODE_ARMED;
               ctl_rx_pos    = '0;
               ctl_sp_accum  = '0;
               ctl_sec_accum = '0;
            end else if (ctl_rx_pos < ttc_pkg::RX_BUFFER_LEN_DEF) begin
               // non-digits count as zero; bytes past the buffer are dropped
               d = (b >= ttc_pkg::CHAR_ZERO && b <= ttc_pkg::CHAR_NINE) ?
                   b - ttc_pkg::CHAR_ZERO : 0;
               if (ctl_rx_pos == POS_TENS)
                  ctl_sp_accum = ctl_sp_accum + d * 100;
               else if (ctl_rx_pos == POS_UNITS)
                  ctl_sp_accum = ctl_sp_accum + d * 10;
               else if (ctl_rx_pos == POS_TENTHS)
                  ctl_sp_accum = ctl_sp_accum + d;
               if (ctl_rx_pos >= ttc_pkg::TIME_FIELD_START_DEF) begin
                  acc = ctl_sec_accum * 10 + d;
                  ctl_sec_accum = (acc > 32'hFFFF) ? 16'hFFFF : 16'(acc);
               end
               ctl_rx_pos = ctl_rx_pos + 1;
            end
         end
         ttc_pkg::KIND_TICK: begin
            if (ctl_tick_count >= cfg_period) begin
               ctl_tick_count = '0;
               period_done = 1'b1;
               if (ctl_countdown_on && ctl_secs_left != 0)
                  ctl_secs_left = ctl_secs_left - 1;
            end else begin
               ctl_tick_count = ctl_tick_count + 1;
            end
         end
         ttc_pkg::KIND_ADC: begin
            acc = item.payload * cfg_gain;
            ctl_temp_milli = 20'(acc);
         end
         default: begin
            // start press only matters when armed
            if (ctl_mode == ttc_pkg::MODE_ARMED) begin
               ctl_heater = 1'b1;
               ctl_mode   = ttc_pkg::MODE_HEAT;
            end
         end
      endcase

      reached = (ctl_temp_milli >= ctl_setpoint * 100);

      case (ctl_mode)
         ttc_pkg::MODE_WAIT: begin
            // display holds; the waiting message shows once
            if (ctl_wait_msg_due) begin
               wait_msg = 1'b1;
               ctl_wait_msg_due = 1'b0;
            end
         end
         ttc_pkg::MODE_ARMED: begin
            deg  = ctl_setpoint / 10;
            hund = (ctl_setpoint % 10) * 10;
            sec  = ctl_secs_left;
         end
         ttc_pkg::MODE_HEAT: begin
            deg  = ctl_temp_milli / 1000;
            hund = (ctl_temp_milli % 1000) / 10;
            sec  = ctl_secs_left;
            if (reached)
               ctl_mode = ttc_pkg::MODE_REG;
         end
         default: begin
            ctl_countdown_on = 1'b1;
            deg  = ctl_temp_milli / 1000;
            hund = (ctl_temp_milli % 1000) / 10;
            sec  = ctl_secs_left;
            ctl_heater = !reached;
            if (ctl_secs_left == 0) begin
               // countdown expired: back to waiting, command cleared
               ctl_mode         = ttc_pkg::MODE_WAIT;
               ctl_heater       = 1'b0;
               ctl_countdown_on = 1'b0;
               ctl_wait_msg_due = 1'b1;
               ctl_setpoint     = '0;
               ctl_rx_pos       = '0;
               ctl_sp_accum     = '0;
               ctl_sec_accum    = '0;
            end
         end
      endcase

      o.heater_on        = ctl_heater;
      o.mode             = ctl_mode;
      o.sample_request   = period_done;
      o.show_waiting     = wait_msg;
      o.display_changed  = (10'(deg) != disp_deg) || (7'(hund) != disp_hund) ||
                           (16'(sec) != disp_sec);
      o.shown_degrees    = 10'(deg);   // degrees wrap at 10 bits
      o.shown_hundredths = 7'(hund);
      o.shown_seconds    = 16'(sec);
      disp_deg  = o.shown_degrees;
      disp_hund = o.shown_hundredths;
      disp_sec  = o.shown_seconds;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Response checking, in order of acceptance
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      ttc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outputs_due.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            want = outputs_due.pop_front();
            check_field("heater_on",        want.heater_on,        rsp_data.heater_on);
            check_field("mode",             want.mode,             rsp_data.mode);
            check_field("sample_request",   want.sample_request,   rsp_data.sample_request);
            check_field("show_waiting",     want.show_waiting,     rsp_data.show_waiting);
            check_field("display_changed",  want.display_changed,  rsp_data.display_changed);
            check_field("shown_degrees",    want.shown_degrees,    rsp_data.shown_degrees);
            check_field("shown_hundredths", want.shown_hundredths, rsp_data.shown_hundredths);
            check_field("shown_seconds",    want.shown_seconds,    rsp_data.shown_seconds);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stalls, ready bursts, and a long hold-off on demand
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         rsp_stall_left   = HOLD_OFF_CYCLES;
         rsp_burst_left   = 0;
      end
      if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left--;
      end else if (rsp_burst_left > 0) begin
         rsp_ready <= 1'b1;
         rsp_burst_left--;
      end else begin
         case ($urandom_range(0, 9))
            0: begin
               rsp_burst_left = $urandom_range(20, 80);
               rsp_ready <= 1'b1;
            end
            1, 2: begin
               rsp_ready <= 1'b0;
               rsp_stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40)
                                                            : $urandom_range(0, 2);
            end
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** timed_thermostat_controller_unit: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request driving
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      int unsigned r;
      if (!sender_gaps)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   // Offers one request, holds it until taken, then logs its expected response.
   // Valid stays high afterwards so back-to-back requests never drop it.
   task automatic send_request(input logic [1:0] kind, input logic [9:0] payload);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= ttc_pkg::req_type'{kind, payload};
      do @(posedge clock); while (!req_ready);
      outputs_due.push_back(advance_controller(req_data));
      items_sent++;
   endtask

   // serial byte with junk in the unused payload bits
   task automatic send_byte(input logic [7:0] b);
      send_request(ttc_pkg::KIND_BYTE, {2'($urandom), b});
   endtask

   task automatic send_text(input string text);
      int i;
      for (i = 0; i < text.len(); i++)
         send_byte(text[i]);
   endtask

   // Sender goes quiet until every response is back, then lets the pipe settle.
   task automatic drain(input int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (outputs_due.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ttc_pkg::CSR_INDEX_W-1:0] index,
                            input logic [ttc_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == ttc_pkg::CSR_TICKS)
         cfg_period = value;
      else if (index == ttc_pkg::CSR_GAIN)
         cfg_gain = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ADC sample, usually close to the point where the setpoint is reached
   function automatic logic [9:0] adc_sample();
      int unsigned thr;
      int v;
      if (cfg_gain == 0 || $urandom_range(0, 2) == 0)
         return 10'($urandom);
      thr = (ctl_setpoint * 100 + cfg_gain - 1) / cfg_gain;
      v = int'(thr) + int'($urandom_range(0, 8)) - 4;
      if (v < 0)
         v = 0;
      if (v > 1023)
         v = 1023;
      return 10'(v);
   endfunction

   // One heating job: command line, start press, then heat-up and countdown
   // steered by the shadow mode. Some jobs are garbled, overlong or cut short,
   // so the next command lands while the controller is busy.
   task automatic run_session(input int unsigned max_secs);
      int unsigned pos, n_digits, steps, cap;
      logic [7:0]  b;
      bit          garble;
      sender_gaps = ($urandom_range(0, 3) != 0);
      garble = ($urandom_range(0, 5) == 0);

      for (pos = 0; pos < ttc_pkg::TIME_FIELD_START_DEF; pos++) begin
         if (pos == POS_TENS || pos == POS_UNITS || pos == POS_TENTHS) begin
            b = (garble && $urandom_range(0, 2) == 0) ?
                8'($urandom) : ttc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
         end else if (garble) begin
            b = 8'($urandom);
         end else begin
            b = (pos == POS_POINT) ? "." : "S";
         end
         send_byte(b);
      end

      // seconds: a short count, or a long digit run that can saturate the count and overflow the buffer
      if ($urandom_range(0, 5) == 0) begin
         n_digits = $urandom_range(5, 16);
         repeat (n_digits) send_byte(ttc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
      end else begin
         send_byte(ttc_pkg::CHAR_ZERO + 8'($urandom_range(0, max_secs)));
      end
      if (!garble || $urandom_range(0, 1) == 0)
         send_byte(ttc_pkg::CHAR_CR);

      if ($urandom_range(0, 4) == 0)
         send_request(2'($urandom), 10'($urandom));
      if ($urandom_range(0, 9) != 0)
         send_request(ttc_pkg::KIND_START, 10'($urandom));

      cap = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 10) : 90;
      for (steps = 0; steps < cap && ctl_mode != ttc_pkg::MODE_WAIT; steps++) begin
         case (ctl_mode)
            ttc_pkg::MODE_ARMED: begin
               if ($urandom_range(0, 1) == 0)
                  send_request(ttc_pkg::KIND_START, 10'($urandom));
               else
                  send_request(ttc_pkg::KIND_TICK, 10'($urandom));
            end
            ttc_pkg::MODE_HEAT: begin
               if ($urandom_range(0, 4) < 3)
                  send_request(ttc_pkg::KIND_ADC, adc_sample());
               else
                  send_request(ttc_pkg::KIND_TICK, 10'($urandom));
            end
            default: begin
               if ($urandom_range(0, 9) < 7)
                  send_request(ttc_pkg::KIND_TICK, 10'($urandom));
               else
                  send_request(ttc_pkg::KIND_ADC, adc_sample());
            end
         endcase
      end
   endtask

   // reconfigure while idle, then run jobs until enough requests went out
   task automatic run_phase(input logic [9:0] period, input logic [9:0] gain,
                            input int unsigned count, input int unsigned max_secs);
      int unsigned first;
      drain(LATENCY_SLACK);
      write_csr(ttc_pkg::CSR_TICKS, period);
      write_csr(ttc_pkg::CSR_GAIN, gain);
      first = items_sent;
      while (items_sent - first < count)
         run_session(max_secs);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // waiting mode: message once, display frozen, start press ignored
   task automatic test_waiting_holds();
      send_request(ttc_pkg::KIND_TICK, '1);
      send_request(ttc_pkg::KIND_START, '0);
      send_request(ttc_pkg::KIND_ADC, '0);
      send_request(ttc_pkg::KIND_ADC, '1);
   endtask

   // command with no seconds digits, top setpoint, then heat-up begins
   task automatic test_short_command();
      send_text("xx99.9");
      send_byte(ttc_pkg::CHAR_CR);
      send_request(ttc_pkg::KIND_START, '0);
      send_request(ttc_pkg::KIND_ADC, '0);
   endtask

   // CR mid-heat re-arms with the heater left on; non-digit tens gives zero;
   // zero seconds ends regulation on the next event
   task automatic test_busy_rearm();
      send_text("  Q");
      send_byte(ttc_pkg::CHAR_CR);
      send_request(ttc_pkg::KIND_START, '1);
      send_request(ttc_pkg::KIND_ADC, '1);
      send_request(ttc_pkg::KIND_TICK, '0);
      send_request(ttc_pkg::KIND_START, '0);
   endtask

   // sample period register set to one, largest gain
   task automatic test_fast_period();
      run_phase(10'd1, '1, 80, 9);
   endtask

   // zero gain: temperature pinned at zero, heat-up rarely finishes
   task automatic test_zero_gain();
      run_phase(10'd4, '0, 30, 3);
   endtask

   // writes to an undecoded index must leave both registers alone
   task automatic test_unknown_register();
      int i;
      drain(LATENCY_SLACK);
      write_csr(CSR_SPARE, '1);
      write_csr(CSR_SPARE, '0);
      for (i = 0; i < 10; i++)
         send_request(2'($urandom), 10'($urandom));
   endtask

   // mid settings, with a full drain in the middle of traffic
   task automatic test_mixed_with_pause();
      run_phase(10'($urandom_range(2, 6)), 10'($urandom_range(200, 800)), 50, 5);
      drain(1);
      run_phase(10'($urandom_range(2, 6)), 10'($urandom_range(200, 800)), 50, 5);
   endtask

   // receiver holds off while requests keep coming: pipeline fills, input stalls
   task automatic test_backpressure();
      int i;
      sender_gaps = 1'b0;
      hold_off_request = 1'b1;
      for (i = 0; i < 40; i++)
         send_request(2'($urandom), 10'($urandom));
      sender_gaps = 1'b1;
   endtask

   // longest sample period: the tick counter climbs well short of it while
   // regulating; full-scale temperature also wraps the degree display
   task automatic test_long_period();
      int unsigned n;
      drain(LATENCY_SLACK);
      write_csr(ttc_pkg::CSR_TICKS, '1);
      write_csr(ttc_pkg::CSR_GAIN, '1);
      sender_gaps = 1'b0;
      send_text("SP50.0 T1");
      send_byte(ttc_pkg::CHAR_CR);
      send_request(ttc_pkg::KIND_START, '0);
      send_request(ttc_pkg::KIND_ADC, '1);
      for (n = 0; n < 40 && ctl_mode != ttc_pkg::MODE_WAIT; n++)
         send_request(ttc_pkg::KIND_TICK, 10'($urandom));
      sender_gaps = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_waiting_holds();
      test_short_command();
      test_busy_rearm();
      test_fast_period();
      test_zero_gain();
      test_unknown_register();
      test_mixed_with_pause();
      test_backpressure();
      test_long_period();

      drain(2 * LATENCY_SLACK);
      if (mismatches == 0 && outputs_due.size() == 0)
         $display("** timed_thermostat_controller_unit: PASSED **");
      else
         $display("** timed_thermostat_controller_unit: FAILED **");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ttc_pkg.sv
rtl/core/timed_thermostat_controller_unit.sv
bench/tb_timed_thermostat_controller_unit.sv
